[sv/mi3_pkg.sv]
`default_nettype none

package mi3_pkg;

	// Field geometry
	localparam int EW = 16;                       // input element width
	localparam int FB = 16;                       // fraction bits of each result
	localparam int OW = 32;                       // result element width
	localparam int NE = 9;                        // elements per matrix

	// Internal widths, all exact for full-range inputs
	localparam int PW   = 2 * EW;                 // element product
	localparam int CW   = 2 * EW + 1;             // signed cofactor
	localparam int CMW  = 2 * EW;                 // cofactor magnitude
	localparam int DPW  = 3 * EW;                 // row-0 element times cofactor
	localparam int DETW = 3 * EW + 1;             // signed determinant
	localparam int DMW  = 3 * EW;                 // determinant magnitude
	localparam int NUMW = DMW + OW;               // scaled dividend
	localparam int QRW  = OW + 1;                 // rounded quotient

	// Pipeline depths
	localparam int FRONT_LAT = 5;                 // products, cofactors, det terms, det, |det|
	localparam int LANE_LAT  = OW + 3;            // setup, one step per quotient bit, round, clamp
	localparam int LAT       = FRONT_LAT + LANE_LAT;
	localparam int DLN       = OW + 2;            // divisor taps used by a lane

	// Stream widths, padded to whole bytes
	localparam int INW  = ((NE * EW + 7) / 8) * 8;
	localparam int OUTW = ((NE * OW + 7) / 8) * 8;

	// Clamp limits as magnitudes
	localparam logic [QRW-1:0] POS_LIM = QRW'((64'd1 << (OW - 1)) - 64'd1);
	localparam logic [QRW-1:0] NEG_LIM = QRW'(64'd1 << (OW - 1));

	typedef logic signed [EW-1:0] elem_t;
	typedef logic signed [CW-1:0] cof_t;
	typedef logic [DMW-1:0]       dmag_t;
	typedef logic signed [OW-1:0] res_t;

	typedef struct packed {
		logic vld;
		logic sing;
	} ctl_t;

	// Row or column index of the first and second survivor when index k is struck out
	function automatic int lo_idx(input int k);
		return (k == 0) ? 1 : 0;
	endfunction

	function automatic int hi_idx(input int k);
		return (k == 2) ? 1 : 2;
	endfunction

endpackage

`default_nettype wire

[sv/mi3_front.sv]
`default_nettype none

module mi3_front import mi3_pkg::*; (
	input  wire        clk,
	input  wire        en,
	input  wire elem_t m [NE],
	output cof_t       cof [NE],
	output dmag_t      dmag,
	output logic       detneg,
	output logic       sing
);

	logic signed [PW-1:0]  pa_d [NE];
	logic signed [PW-1:0]  pb_d [NE];
	logic signed [PW-1:0]  pa_s1 [NE];
	logic signed [PW-1:0]  pb_s1 [NE];
	elem_t                 r0_s1 [3];
	elem_t                 r0_s2 [3];
	cof_t                  cof_d [NE];
	cof_t                  cof_s2 [NE];
	cof_t                  cof_s3 [NE];
	cof_t                  cof_s4 [NE];
	cof_t                  cof_s5 [NE];
	logic signed [DPW-1:0] dp_d [3];
	logic signed [DPW-1:0] dp_s3 [3];
	logic signed [DETW-1:0] det_s4;
	logic [DETW-1:0]       dabs;
	dmag_t                 dmag_s5;
	logic                  neg_s5;
	logic                  sing_s5;

	// Two 2x2 products per minor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pa_d[i * 3 + j] = PW'(m[lo_idx(i) * 3 + lo_idx(j)])
					* PW'(m[hi_idx(i) * 3 + hi_idx(j)]);
				pb_d[i * 3 + j] = PW'(m[lo_idx(i) * 3 + hi_idx(j)])
					* PW'(m[hi_idx(i) * 3 + lo_idx(j)]);
			end
		end
	end

	// Odd positions take the swapped difference to apply the checkerboard sign
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (((i + j) % 2) == 1) begin
					cof_d[i * 3 + j] = CW'(pb_s1[i * 3 + j]) - CW'(pa_s1[i * 3 + j]);
				end else begin
					cof_d[i * 3 + j] = CW'(pa_s1[i * 3 + j]) - CW'(pb_s1[i * 3 + j]);
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			dp_d[j] = DPW'(r0_s2[j]) * DPW'(cof_s2[j]);
		end
	end

	assign dabs = det_s4[DETW-1] ? DETW'(-det_s4) : DETW'(det_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1   <= pa_d;
			pb_s1   <= pb_d;
			r0_s1   <= m[0:2];
			r0_s2   <= r0_s1;
			cof_s2  <= cof_d;
			dp_s3   <= dp_d;
			cof_s3  <= cof_s2;
			det_s4  <= DETW'(dp_s3[0]) + DETW'(dp_s3[1]) + DETW'(dp_s3[2]);
			cof_s4  <= cof_s3;
			dmag_s5 <= dabs[DMW-1:0];
			neg_s5  <= det_s4[DETW-1];
			sing_s5 <= (det_s4 == '0);
			cof_s5  <= cof_s4;
		end
	end

	assign cof    = cof_s5;
	assign dmag   = dmag_s5;
	assign detneg = neg_s5;
	assign sing   = sing_s5;

endmodule

`default_nettype wire

[sv/mi3_lane.sv]
`default_nettype none

module mi3_lane import mi3_pkg::*; (
	input  wire        clk,
	input  wire        en,
	input  wire cof_t  c,
	input  wire        detneg,
	input  wire dmag_t dl [DLN],
	output res_t       res
);

	logic [CW-1:0]   cabs;
	logic [NUMW-1:0] num;
	logic [DMW-1:0]  rem_s [OW+1];
	logic [OW-1:0]   quo_s [OW+1];
	logic            ovf_s [OW+1];
	logic            neg_s [OW+1];
	logic [DMW:0]    r2 [OW];
	logic            ge [OW];
	logic [DMW-1:0]  nrem [OW];
	logic [OW-1:0]   nquo [OW];
	logic            up;
	logic [QRW-1:0]  qr_s39;
	logic            ovf_s39;
	logic            neg_s39;
	logic [QRW-1:0]  lim;
	logic [QRW-1:0]  clamp;
	logic [OW-1:0]   mag;
	res_t            res_s40;

	// Setup: the high part of the dividend at or above the divisor means the
	// quotient spills past the result width; otherwise it seeds the remainder
	assign cabs = c[CW-1] ? CW'(-c) : CW'(c);
	assign num  = NUMW'(cabs[CMW-1:0]) << FB;

	// One restoring step per quotient bit
	always_comb begin
		for (int k = 0; k < OW; k++) begin
			r2[k]   = {rem_s[k], quo_s[k][OW-1]};
			ge[k]   = r2[k] >= {1'b0, dl[k + 1]};
			nrem[k] = ge[k] ? DMW'(r2[k] - {1'b0, dl[k + 1]}) : r2[k][DMW-1:0];
			nquo[k] = {quo_s[k][OW-2:0], ge[k]};
		end
	end

	// Round half away from zero on the magnitude
	assign up = {rem_s[OW], 1'b0} >= {1'b0, dl[OW + 1]};

	assign lim   = neg_s39 ? NEG_LIM : POS_LIM;
	assign clamp = (ovf_s39 || (qr_s39 > lim)) ? lim : qr_s39;
	assign mag   = clamp[OW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num[NUMW-1:OW];
			quo_s[0] <= num[OW-1:0];
			ovf_s[0] <= num[NUMW-1:OW] >= dl[0];
			neg_s[0] <= c[CW-1] ^ detneg;
			for (int k = 0; k < OW; k++) begin
				rem_s[k + 1] <= nrem[k];
				quo_s[k + 1] <= nquo[k];
				ovf_s[k + 1] <= ovf_s[k];
				neg_s[k + 1] <= neg_s[k];
			end
			qr_s39  <= QRW'(quo_s[OW]) + QRW'(up);
			ovf_s39 <= ovf_s[OW];
			neg_s39 <= neg_s[OW];
			res_s40 <= neg_s39 ? -mag : mag;
		end
	end

	assign res = res_s40;

endmodule

`default_nettype wire

[sv/mi3_merge.sv]
`default_nettype none

module mi3_merge import mi3_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire ctl_t        ctl,
	input  wire res_t        res [NE],
	input  wire              m_tready,
	output logic             m_tvalid,
	output logic [OUTW-1:0]  m_tdata,
	output logic             m_tuser,
	output logic             en
);

	logic [OUTW-1:0] pack;
	logic            leave;
	logic            out_v_q;
	logic            skid_v_q;
	logic [OUTW-1:0] out_d_q;
	logic            out_u_q;
	logic [OUTW-1:0] skid_d_q;
	logic            skid_u_q;

	// Zero every element of a singular matrix
	always_comb begin
		pack = '0;
		for (int k = 0; k < NE; k++) begin
			pack[k * OW +: OW] = ctl.sing ? '0 : res[k];
		end
	end

	// The pipeline moves only while the skid slot is free
	assign en    = !skid_v_q;
	assign leave = en && ctl.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_tready) begin
				out_v_q  <= skid_v_q || leave;
				skid_v_q <= 1'b0;
			end else if (leave) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_d_q <= skid_d_q;
				out_u_q <= skid_u_q;
			end else begin
				out_d_q <= pack;
				out_u_q <= ctl.sing;
			end
		end else if (leave) begin
			skid_d_q <= pack;
			skid_u_q <= ctl.sing;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tuser  = out_u_q;

endmodule

`default_nettype wire

[sv/matrix_inverse_3x3_core.sv]
`default_nettype none

// 3x3 matrix inverse, adjugate method, Q15.16 results with saturation.
//
// Input stream (s_*): one beat carries one matrix, nine signed 16-bit elements
// in row-major order. Output stream (m_*): one beat per matrix carrying the
// nine inverse elements, signed 32-bit with 16 fraction bits, clamped to the
// 32-bit range and rounded to nearest with ties away from zero. m_tuser flags
// a singular matrix (zero determinant); all elements of that beat are zero.
//
// Throughput is one matrix per clock while the skid slot is empty. From acceptance
// to m_tvalid a beat passes five front stages (products, cofactors, determinant terms,
// determinant, its magnitude), then nine division lanes side by side, each a
// setup stage, 32 restoring steps (one quotient bit per stage) and two stages
// for rounding and clamping, then the output register. The 32-stage divider is
// what sets the depth.
//
// Reset clears all valid state at once; no beats are in flight afterward.
// When the receiver stalls, the output register holds its beat and one more
// beat drops into a skid slot; the whole pipeline then holds and s_tready falls
// until the slot drains. s_tready comes straight from a register.
module matrix_inverse_3x3_core import mi3_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [INW-1:0]   s_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22, 16 bits each
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [OUTW-1:0]  m_tdata,   // inv00 inv01 inv02 inv10 inv11 inv12 inv20 inv21 inv22
	output logic             m_tuser    // singular
);

	elem_t          m [NE];
	cof_t           cof [NE];
	dmag_t          dmag;
	logic           detneg;
	logic           sing;
	dmag_t          dl [DLN];
	dmag_t          dline_s [DLN-1];
	logic [LAT-1:0] vld_s;
	logic [LANE_LAT-1:0] sing_s;
	res_t           res [NE];
	ctl_t           ctl;
	logic           en;

	// Unpack the beat into elements
	always_comb begin
		for (int k = 0; k < NE; k++) begin
			m[k] = s_tdata[k * EW +: EW];
		end
	end

	mi3_front u_front (
		.clk    (clk),
		.en     (en),
		.m      (m),
		.cof    (cof),
		.dmag   (dmag),
		.detneg (detneg),
		.sing   (sing)
	);

	// Divisor travels beside the lanes, one tap per lane stage, shared by all nine
	always_comb begin
		dl[0] = dmag;
		for (int k = 1; k < DLN; k++) begin
			dl[k] = dline_s[k - 1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dline_s[0] <= dmag;
			for (int k = 1; k < DLN - 1; k++) begin
				dline_s[k] <= dline_s[k - 1];
			end
			sing_s <= {sing_s[LANE_LAT-2:0], sing};
		end
	end

	// Beat-valid line across all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], s_tvalid};
		end
	end

	// Lane r*3+c divides the transposed cofactor C[c][r]
	for (genvar k = 0; k < NE; k++) begin : g_lane
		mi3_lane u_lane (
			.clk    (clk),
			.en     (en),
			.c      (cof[(k % 3) * 3 + (k / 3)]),
			.detneg (detneg),
			.dl     (dl),
			.res    (res[k])
		);
	end

	assign ctl.vld  = vld_s[LAT-1];
	assign ctl.sing = sing_s[LANE_LAT-1];

	mi3_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.res      (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.en       (en)
	);

	assign s_tready = en;

endmodule

`default_nettype wire
